// ===== rtl/bf3_pkg.sv =====
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared types, register indexes and the range weight table builder for the
// 3x3 bilateral filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bf3_pkg;

  localparam int unsigned PixW   = 8;
  localparam int unsigned WtW    = 32;   // range Q16 times spatial Q16
  localparam int unsigned NumW   = 44;   // sum of nine weight*pixel products
  localparam int unsigned DenW   = 36;   // sum of nine weights
  localparam int unsigned RemW   = NumW + 8;
  localparam int unsigned QuotW  = 16;
  localparam int unsigned Taps   = 9;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegImageWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSwCenter    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSwEdge      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSwCorner    = 3'd4;

  localparam logic [3:0] TapCenter = 4'd4;

  typedef logic [15:0] range_lut_t [256];

  typedef struct packed {
    logic                clear;     // write zero at clr_addr
    logic                accept;    // latch incoming pixel
    logic                win;       // update line buffers, window, counters
    logic                mul;       // form weight of the current tap
    logic                acc;       // accumulate the current tap
    logic                acc_last;  // last tap: also load the divider
    logic                div_step;  // one quotient bit
    logic                out_load;  // move result into the output register
    logic [3:0]          tap;
  } bf3_cmd_t;

  typedef struct packed {
    logic emit;      // current pixel is interior
    logic out_free;  // output register can take a result
  } bf3_status_t;

  // Shift-and-subtract quotient, used only while the table is built.
  function automatic longint unsigned div_u64(longint unsigned num,
                                              longint unsigned dsr);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= dsr) begin
        r    = r - dsr;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Range weight exp(-d^2/(2*sigma^2)) in Q16, built at elaboration.
  function automatic range_lut_t build_range_lut(int unsigned Sigma);
    range_lut_t       lut;
    longint unsigned  d2, den, n, f, term, v;
    longint           acc;
    for (int d = 0; d < 256; d++) begin
      d2   = longint'(d) * longint'(d);
      den  = 2 * longint'(Sigma) * longint'(Sigma);
      n    = div_u64(d2, den);
      f    = div_u64((d2 - n * den) << 32, den);
      term = 64'd1 << 32;
      acc  = 64'sd1 << 32;
      for (int k = 1; k <= 16; k++) begin
        term = div_u64((term * f) >> 32, longint'(k));
        if ((k & 1) == 1) acc = acc - longint'(term);
        else              acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      v = longint'(acc);
      if (n > 24) begin
        lut[d] = 16'd0;
      end else begin
        for (longint unsigned j = 0; j < n; j++) v = (v * 64'd1580030169) >> 32;
        v = (v + 64'h8000) >> 16;
        lut[d] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
      end
    end
    return lut;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bf3_ctrl.sv =====
// ----------------------------------------------------------------------------
// bf3_ctrl
// Sequencer: line buffer clear after reset, window update, nine-tap
// multiply-accumulate and the bit-serial divide.
// ----------------------------------------------------------------------------
`default_nettype none

module bf3_ctrl #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  bf3_pkg::bf3_status_t          status_i,
  output bf3_pkg::bf3_cmd_t             cmd_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  clr_addr_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_WIN   = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_ACC   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e        state_q, state_d;
  logic [3:0]    tap_q, tap_d;
  logic [3:0]    step_q, step_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign clr_addr_o = clr_q;

  always_comb begin
    state_d = state_q;
    tap_d   = tap_q;
    step_d  = step_q;
    clr_d   = clr_q;
    cmd_o   = '0;
    cmd_o.tap = tap_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(MAX_WIDTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd_o.accept = accept;
        if (accept) begin
          state_d = S_WIN;
        end
      end
      S_WIN: begin
        cmd_o.win = 1'b1;
        tap_d = '0;
        state_d = status_i.emit ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        tap_d = tap_q + 4'd1;
        if (tap_q == 4'(bf3_pkg::Taps - 1)) begin
          cmd_o.acc_last = 1'b1;
          step_d  = '0;
          state_d = S_DIV;
        end else begin
          state_d = S_MUL;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 4'd1;
        if (step_q == 4'(bf3_pkg::QuotW - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      tap_q   <= '0;
      step_q  <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
      step_q  <= step_d;
      clr_q   <= clr_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bf3_datapath.sv =====
// ----------------------------------------------------------------------------
// bf3_datapath
// Line buffers, 3x3 window, geometry counters, configuration registers,
// weight multiply-accumulate, restoring divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bf3_datapath #(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned RANGE_SIGMA = 12
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [bf3_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  wire  [bf3_pkg::CfgDataW-1:0]         cfg_data_i,
  input  wire  [bf3_pkg::PixW-1:0]             pixel_i,
  input  bf3_pkg::bf3_cmd_t                    cmd_i,
  input  wire  [$clog2(MAX_WIDTH)-1:0]         clr_addr_i,
  output bf3_pkg::bf3_status_t                 status_o,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic [bf3_pkg::QuotW-1:0]            out_value_o,
  output logic                                 out_last_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW = (WW > 11) ? WW : 11;
  localparam bf3_pkg::range_lut_t RangeLut = bf3_pkg::build_range_lut(RANGE_SIGMA);

  localparam int unsigned PW = bf3_pkg::PixW;

  // configuration
  logic [10:0] width_q;
  logic [15:0] height_q, sw_center_q, sw_edge_q, sw_corner_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= 11'd640;
      height_q    <= 16'd480;
      sw_center_q <= 16'd65535;
      sw_edge_q   <= 16'd65407;
      sw_corner_q <= 16'd65280;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bf3_pkg::RegImageWidth:  width_q     <= cfg_data_i[10:0];
        bf3_pkg::RegImageHeight: height_q    <= cfg_data_i;
        bf3_pkg::RegSwCenter:    sw_center_q <= cfg_data_i;
        bf3_pkg::RegSwEdge:      sw_edge_q   <= cfg_data_i;
        bf3_pkg::RegSwCorner:    sw_corner_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [CW-1:0] width_ext;
  logic [WW-1:0] w_eff;
  logic [15:0]   h_eff;

  assign width_ext = CW'(width_q);
  always_comb begin
    if (width_ext < CW'(3))              w_eff = WW'(3);
    else if (width_ext > CW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else                                 w_eff = width_ext[WW-1:0];
  end
  assign h_eff = (height_q < 16'd3) ? 16'd3 : height_q;

  // counters
  logic [AW-1:0] col_q;
  logic [15:0]   row_q;
  logic          col_end, row_end, geom_wr;

  assign col_end = (WW'(col_q) == w_eff - WW'(1));
  assign row_end = (row_q == h_eff - 16'd1);
  assign geom_wr = cfg_we_i && (cfg_index_i == bf3_pkg::RegImageWidth ||
                                cfg_index_i == bf3_pkg::RegImageHeight);
  assign status_o.emit = (row_q >= 16'd2) && (col_q >= AW'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (geom_wr) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.win) begin
      if (col_end) begin
        col_q <= '0;
        row_q <= row_end ? 16'd0 : row_q + 16'd1;
      end else begin
        col_q <= col_q + AW'(1);
      end
    end
  end

  // line buffers
  logic [PW-1:0] line_up_mem [MAX_WIDTH];
  logic [PW-1:0] line_lo_mem [MAX_WIDTH];
  logic [PW-1:0] up_rd_q, lo_rd_q, px_q;
  logic [AW-1:0] wr_addr;
  logic          mem_we;

  assign mem_we  = cmd_i.clear || cmd_i.win;
  assign wr_addr = cmd_i.clear ? clr_addr_i : col_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_up_mem[wr_addr] <= cmd_i.clear ? '0 : lo_rd_q;
      line_lo_mem[wr_addr] <= cmd_i.clear ? '0 : px_q;
    end
    up_rd_q <= line_up_mem[col_q];
    lo_rd_q <= line_lo_mem[col_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) px_q <= pixel_i;
  end

  // window
  logic [PW-1:0] taps_q [bf3_pkg::Taps];
  logic          last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) taps_q[i] <= '0;
      last_q <= 1'b0;
    end else if (cmd_i.win) begin
      for (int r = 0; r < 3; r++) begin
        taps_q[r*3]   <= taps_q[r*3+1];
        taps_q[r*3+1] <= taps_q[r*3+2];
      end
      taps_q[2] <= up_rd_q;
      taps_q[5] <= lo_rd_q;
      taps_q[8] <= px_q;
      last_q    <= row_end && col_end;
    end
  end

  // weight of the current tap
  logic [PW-1:0] tap_px, centre, diff;
  logic [15:0]   sw_sel;
  logic [bf3_pkg::WtW-1:0] wt_q;

  assign tap_px = taps_q[cmd_i.tap];
  assign centre = taps_q[bf3_pkg::TapCenter];
  assign diff   = (tap_px > centre) ? tap_px - centre : centre - tap_px;

  always_comb begin
    case (cmd_i.tap) inside
      bf3_pkg::TapCenter:        sw_sel = sw_center_q;
      4'd1, 4'd3, 4'd5, 4'd7:    sw_sel = sw_edge_q;
      default:                   sw_sel = sw_corner_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) wt_q <= bf3_pkg::WtW'(RangeLut[diff]) * bf3_pkg::WtW'(sw_sel);
  end

  // accumulate
  logic [bf3_pkg::NumW-1:0] num_q, num_d;
  logic [bf3_pkg::DenW-1:0] den_q, den_d;
  logic [bf3_pkg::WtW+PW-1:0] prod;

  assign prod  = (bf3_pkg::WtW+PW)'(wt_q) * (bf3_pkg::WtW+PW)'(tap_px);
  assign num_d = num_q + bf3_pkg::NumW'(prod);
  assign den_d = den_q + bf3_pkg::DenW'(wt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.win) begin
      num_q <= '0;
      den_q <= '0;
    end else if (cmd_i.acc) begin
      num_q <= num_d;
      den_q <= den_d;
    end
  end

  // restoring divide, one quotient bit per cycle
  localparam int unsigned DsW = bf3_pkg::DenW + bf3_pkg::QuotW - 1;
  logic [bf3_pkg::RemW-1:0]  rem_q;
  logic [DsW-1:0]            dsh_q;
  logic [bf3_pkg::QuotW-1:0] quot_q;
  logic                      fits;

  assign fits = rem_q >= bf3_pkg::RemW'(dsh_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_last) begin
      rem_q  <= {num_d, 8'd0};
      dsh_q  <= {den_d, (bf3_pkg::QuotW-1)'(0)};
      quot_q <= '0;
    end else if (cmd_i.div_step) begin
      if (fits) rem_q <= rem_q - bf3_pkg::RemW'(dsh_q);
      quot_q <= {quot_q[bf3_pkg::QuotW-2:0], fits};
      dsh_q  <= dsh_q >> 1;
    end
  end

  // output register
  logic                      out_valid_q;
  logic [bf3_pkg::QuotW-1:0] out_value_q;
  logic                      out_last_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_value_q <= (den_q == '0) ? {centre, 8'd0} : quot_q;
      out_last_q  <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/bilateral_filter_3x3.sv =====
// ----------------------------------------------------------------------------
// bilateral_filter_3x3
// Streaming 3x3 bilateral filter for 8-bit grayscale, 8.8 fixed-point result.
//
// Channel   Dir  Signals                         Content
// s_axis    in   tvalid/tready/tdata[7:0]        pixel, raster order
// m_axis    out  tvalid/tready/tdata[15:0]/tlast filtered_value, frame_last
// cfg       in   cfg_we_i/cfg_index_i/cfg_data_i register writes
//
// Border pixel: after accept the sequencer does the window update and goes
// back to idle for the next item. Interior pixel: the window update, a
// multiply and an accumulate step per tap over nine taps on one multiplier,
// sixteen divider steps and one output load come before the result is valid
// and the next item is taken. After reset the line buffers are cleared over
// all MAX_WIDTH entries; no pixel is accepted then. A result waits in the
// output register while the next pixel is taken; the sequencer stalls only if that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module bilateral_filter_3x3 #(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned RANGE_SIGMA = 12
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [2:0]                   cfg_index_i,
  input  wire  [15:0]                  cfg_data_i,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [7:0]                   s_axis_tdata,   // [7:0] pixel
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [15:0]                  m_axis_tdata,   // [15:0] filtered_value
  output logic                         m_axis_tlast
);

  bf3_pkg::bf3_cmd_t            cmd;
  bf3_pkg::bf3_status_t         status;
  logic [$clog2(MAX_WIDTH)-1:0] clr_addr;

  bf3_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd),
    .clr_addr_o (clr_addr)
  );

  bf3_datapath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .RANGE_SIGMA (RANGE_SIGMA)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pixel_i     (s_axis_tdata),
    .cmd_i       (cmd),
    .clr_addr_i  (clr_addr),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata <= 16'hFF00)
    else $error("filtered value above 255.0");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("pixel accepted while previous one still in work");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("output register overwritten while held");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3x3 bilateral filter: streams small grayscale
// frames through the block under several geometries and spatial weights,
// predicts each interior result and compares it against the output stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int unsigned MaxW = 1024;
  localparam int unsigned Sigma = 12;
  localparam int unsigned WatchLimit = 20000;
  localparam logic [2:0]  RegUnused = 3'd7;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
  } filt_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  bilateral_filter_3x3 #(.MAX_WIDTH(MaxW), .RANGE_SIGMA(Sigma)) dut (.*);

  always #6 clk_i = ~clk_i;

  // ---- predictor state
  logic [15:0] rng_wt [256];
  logic [7:0]  line_mem [2*MaxW];
  logic [7:0]  win [9];
  int unsigned row_n, col_n;
  int unsigned cur_w, cur_h, sw_c, sw_e, sw_k;

  filt_res_t   expected_q[$];
  logic [7:0]  pixel_q[$];
  int          fail_cnt = 0;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  int          hold_off = 0;
  int          idle_cycles = 0;

  function automatic logic [15:0] gauss_weight(int unsigned d);
    longint unsigned d2, den, n, f, term, v;
    longint acc;
    d2 = longint'(d) * d;
    den = 2 * Sigma * Sigma;
    n = d2 / den;
    f = ((d2 % den) << 32) / den;
    term = 64'd1 << 32;
    acc = 64'sd1 << 32;
    for (int k = 1; k <= 16; k++) begin
      term = ((term * f) >> 32) / k;
      if (k & 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    v = acc;
    if (n > 24) return 16'd0;
    for (longint unsigned j = 0; j < n; j++) v = (v * 64'd1580030169) >> 32;
    v = (v + 64'h8000) >> 16;
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic void reg_write_model(logic [2:0] idx, logic [15:0] val);
    case (idx)
      bf3_pkg::RegImageWidth: begin
        cur_w = val & 16'h7FF; row_n = 0; col_n = 0;
      end
      bf3_pkg::RegImageHeight: begin
        cur_h = val; row_n = 0; col_n = 0;
      end
      bf3_pkg::RegSwCenter: sw_c = val;
      bf3_pkg::RegSwEdge:   sw_e = val;
      bf3_pkg::RegSwCorner: sw_k = val;
      default: ;
    endcase
  endfunction

  function automatic void filter_pixel(logic [7:0] px);
    int unsigned w, h, c, r, centre, p, dif, sw;
    logic [7:0] up, lo;
    longint unsigned num, den, wt, res;
    filt_res_t e;
    w = cur_w < 3 ? 3 : (cur_w > MaxW ? MaxW : cur_w);
    h = cur_h < 3 ? 3 : cur_h;
    c = col_n; r = row_n;
    if (c >= w) c = w - 1;
    up = line_mem[c];
    lo = line_mem[MaxW + c];
    line_mem[c] = lo;
    line_mem[MaxW + c] = px;
    for (int i = 0; i < 3; i++) begin
      win[i*3] = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = up; win[5] = lo; win[8] = px;
    if (r >= 2 && c >= 2) begin
      centre = win[4];
      num = 0; den = 0;
      for (int rr = 0; rr < 3; rr++)
        for (int cc = 0; cc < 3; cc++) begin
          p = win[rr*3+cc];
          dif = p > centre ? p - centre : centre - p;
          if (rr == 1 && cc == 1) sw = sw_c;
          else if (rr != 1 && cc != 1) sw = sw_k;
          else sw = sw_e;
          wt = longint'(rng_wt[dif]) * sw;
          num += wt * p;
          den += wt;
        end
      res = den ? (num << 8) / den : (longint'(centre) << 8);
      e.value = res[15:0];
      e.last = (r == h - 1 && c == w - 1);
      expected_q.push_back(e);
    end
    c++;
    if (c >= w) begin
      c = 0; r++;
      if (r >= h) r = 0;
    end
    col_n = c; row_n = r;
  endfunction

  // ---- driver
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      filter_pixel(s_axis_tdata);
      void'(pixel_q.pop_front());
    end
    if ((!s_axis_tvalid || s_axis_tready) && rst_ni) begin
      if (s_axis_tvalid && s_axis_tready && pixel_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        // head of queue is the next item once the accepted one is popped
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pixel_q[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---- monitor and receiver
  always @(posedge clk_i) begin
    filt_res_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result value=%h last=%b", $time, m_axis_tdata,
                 m_axis_tlast);
        fail_cnt++;
      end else begin
        e = expected_q.pop_front();
        if (e.value !== m_axis_tdata || e.last !== m_axis_tlast) begin
          $display("%0t: mismatch expected value=%h last=%b actual value=%h last=%b",
                   $time, e.value, e.last, m_axis_tdata, m_axis_tlast);
          fail_cnt++;
        end
      end
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---- watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        !rst_ni || hold_off > 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    reg_write_model(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pixel_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0)
      @(posedge clk_i);
    // a border pixel may still be in flight
    repeat (50) @(posedge clk_i);
  endtask

  task automatic push_frame(int unsigned w, int unsigned h, int mode);
    for (int unsigned i = 0; i < w * h; i++) begin
      case (mode)
        0: pixel_q.push_back(8'($urandom_range(255)));
        1: pixel_q.push_back(((i % 2) ^ ((i / w) % 2)) ? 8'hFF : 8'h00);
        2: pixel_q.push_back(8'(118 + $urandom_range(20)));
        default: pixel_q.push_back($urandom_range(1) ? 8'hFF : 8'h00);
      endcase
    end
  endtask

  initial begin
    int unsigned w, h;
    for (int d = 0; d < 256; d++) rng_wt[d] = gauss_weight(d);
    for (int i = 0; i < 2 * MaxW; i++) line_mem[i] = '0;
    for (int i = 0; i < 9; i++) win[i] = '0;
    row_n = 0; col_n = 0;
    cur_w = 640; cur_h = 480; sw_c = 65535; sw_e = 65407; sw_k = 65280;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: tiny frame with extremes, zero weights, out-of-range geometry
    cfg_write(bf3_pkg::RegImageWidth, 16'd4);
    cfg_write(bf3_pkg::RegImageHeight, 16'd4);
    pixel_q.push_back(8'h00); pixel_q.push_back(8'hFF); pixel_q.push_back(8'h00);
    pixel_q.push_back(8'hFF); pixel_q.push_back(8'h80); pixel_q.push_back(8'h7F);
    pixel_q.push_back(8'hFF); pixel_q.push_back(8'h00); pixel_q.push_back(8'h01);
    pixel_q.push_back(8'hFE); pixel_q.push_back(8'h55); pixel_q.push_back(8'hAA);
    pixel_q.push_back(8'hFF); pixel_q.push_back(8'h00); pixel_q.push_back(8'hFF);
    pixel_q.push_back(8'h00);
    wait_drained();
    cfg_write(bf3_pkg::RegSwCenter, 16'd0);
    cfg_write(bf3_pkg::RegSwEdge, 16'd0);
    cfg_write(bf3_pkg::RegSwCorner, 16'd0);
    cfg_write(bf3_pkg::RegImageWidth, 16'd1);   // acts as 3
    cfg_write(bf3_pkg::RegImageHeight, 16'd0);  // acts as 3
    push_frame(3, 3, 0);
    wait_drained();
    cfg_write(RegUnused, 16'hFFFF);
    cfg_write(bf3_pkg::RegSwCenter, 16'hFFFF);
    cfg_write(bf3_pkg::RegSwEdge, 16'h0001);
    cfg_write(bf3_pkg::RegSwCorner, 16'hFFFF);
    push_frame(3, 3, 1);
    wait_drained();
    // upper bits of the width write are dropped: width 5
    cfg_write(bf3_pkg::RegImageWidth, 16'hF805);
    cfg_write(bf3_pkg::RegImageHeight, 16'd3);
    push_frame(5, 3, 2);
    wait_drained();

    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      w = $urandom_range(14, 3);
      h = $urandom_range(10, 3);
      cfg_write(bf3_pkg::RegImageWidth, 16'(w));
      cfg_write(bf3_pkg::RegImageHeight, 16'(h));
      cfg_write(bf3_pkg::RegSwCenter, (ph == 4) ? 16'd0 : 16'($urandom_range(65535)));
      cfg_write(bf3_pkg::RegSwEdge, (ph == 5) ? 16'hFFFF : 16'($urandom_range(65535)));
      cfg_write(bf3_pkg::RegSwCorner, (ph == 6) ? 16'd0 : 16'($urandom_range(65535)));
      if (ph == 2) hold_off = 400;
      for (int f = 0; f < 2; f++) push_frame(w, h, (ph + f) % 4);
      wait_drained();
    end

    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
